/* src/ubd_pkg.sv */
// shared constants, types and lead byte decode for the utf-8 code point decoder
`default_nettype none

package ubd_pkg;

    // field widths of the two channels
    localparam int ByteWidth = 8;
    localparam int CpWidth   = 16;

    // byte class boundaries
    localparam logic [ByteWidth-1:0] ContBase  = 8'h80;
    localparam logic [ByteWidth-1:0] Lead2Base = 8'hC0;
    localparam logic [ByteWidth-1:0] Lead3Base = 8'hE0;
    localparam logic [ByteWidth-1:0] Lead4Base = 8'hF0;
    localparam logic [ByteWidth-1:0] Lead5Base = 8'hF8;
    localparam logic [ByteWidth-1:0] Lead6Base = 8'hFC;

    // code point sent for stray or unsupported bytes
    localparam logic [CpWidth-1:0] UnknownCp = 16'h003F;

    // continuation bytes swallowed after unsupported leads
    localparam logic [2:0] Skip4 = 3'd3;
    localparam logic [2:0] Skip5 = 3'd4;
    localparam logic [2:0] Skip6 = 3'd5;

    // one result word
    typedef struct packed {
        logic [CpWidth-1:0] point_val;
        logic               malformed;
        logic               run_end;
    } result_t;

    // outcome of decoding a byte with no sequence open
    typedef struct packed {
        logic               emit;
        logic [CpWidth-1:0] point_val;
        logic               malformed;
        logic [CpWidth-1:0] partial_value;
        logic [1:0]         bytes_awaited;
        logic [2:0]         skip_left;
    } fresh_t;

    // decode a byte from a clean state
    function automatic fresh_t decode_fresh(input logic [ByteWidth-1:0] b);
        fresh_t f;
        begin
            f = '0;
            priority if (b >= Lead6Base)
            begin
                f.emit      = 1'b1;
                f.point_val = UnknownCp;
                f.malformed = 1'b1;
                f.skip_left = Skip6;
            end
            else if (b >= Lead5Base)
            begin
                f.emit      = 1'b1;
                f.point_val = UnknownCp;
                f.malformed = 1'b1;
                f.skip_left = Skip5;
            end
            else if (b >= Lead4Base)
            begin
                f.emit      = 1'b1;
                f.point_val = UnknownCp;
                f.malformed = 1'b1;
                f.skip_left = Skip4;
            end
            else if (b >= Lead3Base)
            begin
                f.partial_value = {b[3:0], 12'b0};
                f.bytes_awaited = 2'd2;
            end
            else if (b >= Lead2Base)
            begin
                f.partial_value = {5'b0, b[4:0], 6'b0};
                f.bytes_awaited = 2'd1;
            end
            else if (b < ContBase)
            begin
                f.emit      = 1'b1;
                f.point_val = {8'b0, b};
                f.malformed = 1'b0;
            end
            else
            begin
                f.emit      = 1'b1;
                f.point_val = UnknownCp;
                f.malformed = 1'b1;
            end
            return f;
        end
    endfunction

endpackage

`default_nettype wire

/* src/ubd_if.sv */
// stream interfaces for raw bytes and decoded code points
`default_nettype none

// raw byte stream
interface ubd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [ubd_pkg::ByteWidth-1:0] data_byte;
    logic                          final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// code point stream
interface ubd_cp_if;
    logic                        valid;
    logic                        ready;
    logic [ubd_pkg::CpWidth-1:0] point_val;
    logic                        malformed;
    logic                        run_end;

    modport source (output valid, output point_val, output malformed, output run_end,
                    input ready);
    modport sink   (input valid, input point_val, input malformed, input run_end,
                    output ready);
endinterface

`default_nettype wire

/* src/utf8_bmp_decoder.sv */
// utf-8 to 16-bit code point decoder, one byte per clock while the sink keeps up
//
//   channel  dir  fields                               handshake
//   octets   in   data_byte[7:0], final_byte           valid/ready
//   points   out  point_val[15:0], malformed, run_end  valid/ready
//
// a byte is decoded in the cycle it is accepted, against the sequence state
// registers; its zero, one or two result words go into a three-slot queue whose
// head is the output register, so each result word is registered before it is output.
// one byte per clock while the sink keeps up; a byte that yields two words
// can hold the byte side back, since the output port takes a single word at a time.
// ready depends only on the queue fill, so a stalled sink holds the queue and
// backs up the byte side after at most two words are waiting.
// reset clears the sequence state and empties the queue.
`default_nettype none

module utf8_bmp_decoder (
    input  wire          clk,
    input  wire          rst_n,
    ubd_byte_if.sink     octets,
    ubd_cp_if.source     points
);

    // sequence state
    logic [ubd_pkg::CpWidth-1:0] pv_reg, pv_next;
    logic [1:0]                  aw_reg, aw_next;
    logic [2:0]                  skip_reg, skip_next;

    // result queue, slot zero is the output register
    ubd_pkg::result_t slot_reg [3];
    ubd_pkg::result_t slot_next [3];
    logic [1:0]       cnt_reg, cnt_next;

    ubd_pkg::result_t res [2];
    logic [1:0]       n_res;
    logic             is_cont;
    logic             accept;
    logic             pop;

    assign is_cont = (octets.data_byte[7:6] == 2'b10);
    assign accept  = octets.valid && octets.ready;
    assign pop     = (cnt_reg != 2'd0) && points.ready;

    // room for two words before taking a byte
    assign octets.ready = !cnt_reg[1];

    // decode one byte against the open sequence
    always_comb
    begin
        ubd_pkg::fresh_t f;
        logic            use_fresh;
        f         = ubd_pkg::decode_fresh(octets.data_byte);
        use_fresh = 1'b0;
        pv_next   = pv_reg;
        aw_next   = aw_reg;
        skip_next = skip_reg;
        n_res     = 2'd0;
        res[0]    = '0;
        res[1]    = '0;

        if (aw_reg != 2'd0)
        begin
            if (is_cont)
            begin
                if (aw_reg >= 2'd2)
                begin
                    pv_next = pv_reg | {4'b0, octets.data_byte[5:0], 6'b0};
                    aw_next = 2'd1;
                end
                else
                begin
                    res[0] = '{point_val: pv_reg | {10'b0, octets.data_byte[5:0]},
                               malformed: 1'b0, run_end: 1'b0};
                    n_res   = 2'd1;
                    pv_next = '0;
                    aw_next = 2'd0;
                end
            end
            else
            begin
                // cut short by a non-continuation byte
                res[0]    = '{point_val: pv_reg, malformed: 1'b1, run_end: 1'b0};
                n_res     = 2'd1;
                use_fresh = 1'b1;
            end
        end
        else if (skip_reg != 3'd0)
        begin
            if (is_cont)
            begin
                skip_next = skip_reg - 3'd1;
            end
            else
            begin
                use_fresh = 1'b1;
            end
        end
        else
        begin
            use_fresh = 1'b1;
        end

        // byte from a clean state
        if (use_fresh)
        begin
            pv_next   = f.partial_value;
            aw_next   = f.bytes_awaited;
            skip_next = f.skip_left;
            if (f.emit)
            begin
                res[n_res[0]] = '{point_val: f.point_val, malformed: f.malformed,
                                  run_end: 1'b0};
                n_res = n_res + 2'd1;
            end
        end

        // end of string flushes an open sequence
        if (octets.final_byte)
        begin
            if (aw_next != 2'd0)
            begin
                res[n_res[0]] = '{point_val: pv_next, malformed: 1'b1, run_end: 1'b0};
                n_res = n_res + 2'd1;
            end
            pv_next   = '0;
            aw_next   = 2'd0;
            skip_next = 3'd0;
        end

        // mark the last word of this byte
        if (n_res == 2'd2)
        begin
            res[1].run_end = 1'b1;
        end
        else if (n_res == 2'd1)
        begin
            res[0].run_end = 1'b1;
        end
    end

    // queue shift and push
    always_comb
    begin
        logic [1:0] base;
        logic [1:0] n_push;
        n_push   = accept ? n_res : 2'd0;
        base     = cnt_reg - {1'b0, pop};
        cnt_next = base + n_push;

        slot_next[0] = pop ? slot_reg[1] : slot_reg[0];
        slot_next[1] = pop ? slot_reg[2] : slot_reg[1];
        slot_next[2] = slot_reg[2];

        if (n_push != 2'd0)
        begin
            slot_next[base] = res[0];
        end
        if (n_push == 2'd2)
        begin
            slot_next[base + 2'd1] = res[1];
        end
    end

    // sequence state and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= '0;
            aw_reg   <= 2'd0;
            skip_reg <= 3'd0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                pv_reg   <= pv_next;
                aw_reg   <= aw_next;
                skip_reg <= skip_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
        slot_reg[2] <= slot_next[2];
    end

    // output port
    assign points.valid     = (cnt_reg != 2'd0);
    assign points.point_val = slot_reg[0].point_val;
    assign points.malformed = slot_reg[0].malformed;
    assign points.run_end   = slot_reg[0].run_end;

    // an open sequence never coexists with a swallow count
    a_aw_skip_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (aw_reg != 2'd0) |-> (skip_reg == 3'd0))
        else $error("sequence open while swallowing");

    // partial value is clear whenever no sequence is open
    a_pv_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (aw_reg == 2'd0) |-> (pv_reg == '0))
        else $error("stale partial value");

    // a word without run_end always has its partner queued behind it
    a_run_end_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (points.valid && !points.run_end) |-> (cnt_reg >= 2'd2))
        else $error("first word of a pair queued alone");

    // end of string leaves the sequence state clean
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && octets.final_byte) |=>
            (aw_reg == 2'd0 && skip_reg == 3'd0 && pv_reg == '0))
        else $error("state left open after final byte");

endmodule

`default_nettype wire
